>>> rtl/core/rbch_pkg.sv
// ----------------------------------------------------------------------------
// rbch_pkg: shared widths and constants for the ray/box closest-hit block
// Field widths, distance formats and the box limit used by every file.
// ----------------------------------------------------------------------------
package rbch_pkg;

   // box limit per list and the width of the arrival counter
   localparam int MAX_BOXES = 256;
   localparam int CNT_W     = $clog2(MAX_BOXES + 1);

   // field widths
   localparam int COORD_W = 32;
   localparam int DIR_W   = 16;
   localparam int IDX_W   = 8;
   localparam int DIST_W  = 32;

   // plane distance: (corner - origin) * 2^15, magnitude and signed forms
   localparam int FRAC_SHIFT = 15;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int NUM_W      = DIFF_W + FRAC_SHIFT;
   localparam int T_W        = NUM_W + 1;
   localparam int DMAG_W     = DIR_W + 1;
   localparam int DCNT_W     = $clog2(NUM_W);

   // configuration port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

endpackage

>>> rtl/core/rbch_req_if.sv
// ----------------------------------------------------------------------------
// rbch_req_if: box request channel
// Valid/ready channel carrying two opposite corners and the last-box flag.
// ----------------------------------------------------------------------------
interface rbch_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [rbch_pkg::COORD_W-1:0] corner_a_x;
   logic signed [rbch_pkg::COORD_W-1:0] corner_a_y;
   logic signed [rbch_pkg::COORD_W-1:0] corner_a_z;
   logic signed [rbch_pkg::COORD_W-1:0] corner_b_x;
   logic signed [rbch_pkg::COORD_W-1:0] corner_b_y;
   logic signed [rbch_pkg::COORD_W-1:0] corner_b_z;
   logic                                last_box;

   modport source (output valid, corner_a_x, corner_a_y, corner_a_z,
                   corner_b_x, corner_b_y, corner_b_z, last_box, input ready);
   modport sink   (input valid, corner_a_x, corner_a_y, corner_a_z,
                   corner_b_x, corner_b_y, corner_b_z, last_box, output ready);
endinterface

// ----------------------------------------------------------------------------
// rbch_rsp_if: closest-hit result channel
// Valid/ready channel carrying hit flag, box index and entry distance.
// ----------------------------------------------------------------------------
interface rbch_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               hit_found;
   logic [rbch_pkg::IDX_W-1:0]         hit_index;
   logic signed [rbch_pkg::DIST_W-1:0] hit_distance;

   modport source (output valid, hit_found, hit_index, hit_distance, input ready);
   modport sink   (input valid, hit_found, hit_index, hit_distance, output ready);
endinterface

>>> rtl/core/ray_box_closest_hit.sv
// ----------------------------------------------------------------------------
// ray_box_closest_hit: ray against a stream of boxes, closest entry distance
// Slab test per axis through one shared bit-serial divider.
// ----------------------------------------------------------------------------
// Usage:
//  - Write the ray origin (Q16.16) and direction (Q1.15) over the csr_ port
//    while the block is idle. Registers lie at byte addresses 0,4,..,20.
//  - Send boxes on req_box, one request per box. A request with last_box set
//    closes the list: one result then appears on rsp_hit and the tracking
//    clears. Other requests give no result.
//  - Each axis with a nonzero direction runs two divisions on the shared
//    restoring divider, one quotient bit per cycle. A zero-direction axis
//    takes a single setup step; decide and finish steps close each box.
//    Boxes beyond the list limit skip the test and go straight to finish.
//  - req_box.ready is high only while no box is in work.
//  - The result sits in an output register; a stalled receiver holds it and
//    the block goes on with the next list meanwhile. A later result waits
//    in the finish step until the register frees.
//  - Synchronous reset restores the register defaults and clears tracking.
// ----------------------------------------------------------------------------
module ray_box_closest_hit (
   input  logic                              clock,
   input  logic                              reset,
   rbch_req_if.sink                          req_box,
   rbch_rsp_if.source                        rsp_hit,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rbch_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rbch_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rbch_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   // register indexes
   localparam logic [2:0] REG_ORIGIN_X = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [2:0] REG_DIR_X    = 3'd3;
   localparam logic [2:0] REG_DIR_Y    = 3'd4;
   localparam logic [2:0] REG_DIR_Z    = 3'd5;

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SETUP  = 3'd1;
   localparam logic [2:0] S_DIV    = 3'd2;
   localparam logic [2:0] S_APPLY  = 3'd3;
   localparam logic [2:0] S_DECIDE = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   localparam logic [1:0] AXIS_LAST = 2'd2;

   localparam logic signed [rbch_pkg::T_W-1:0] T_NEG_INF =
      {1'b1, {(rbch_pkg::T_W-1){1'b0}}};
   localparam logic signed [rbch_pkg::T_W-1:0] T_POS_INF =
      {1'b0, {(rbch_pkg::T_W-1){1'b1}}};
   localparam logic signed [rbch_pkg::T_W-1:0] T_DIST_MAX =
      rbch_pkg::T_W'({1'b0, {(rbch_pkg::DIST_W-1){1'b1}}});
   localparam logic signed [rbch_pkg::T_W-1:0] T_DIST_MIN =
      {{(rbch_pkg::T_W-rbch_pkg::DIST_W+1){1'b1}}, {(rbch_pkg::DIST_W-1){1'b0}}};
   localparam logic signed [rbch_pkg::DIST_W-1:0] DIST_MAX =
      {1'b0, {(rbch_pkg::DIST_W-1){1'b1}}};

   // configuration registers
   logic signed [rbch_pkg::COORD_W-1:0] origin_ff [3];
   logic signed [rbch_pkg::DIR_W-1:0]   dir_ff    [3];

   // box in work
   logic signed [rbch_pkg::COORD_W-1:0] corner_a_ff [3];
   logic signed [rbch_pkg::COORD_W-1:0] corner_b_ff [3];
   logic                                last_ff, last_in;
   logic [2:0]                          state_ff, state_in;
   logic [1:0]                          axis_ff, axis_in;
   logic                                side_ff, side_in;
   logic                                ok_ff, ok_in;
   logic signed [rbch_pkg::T_W-1:0]     enter_ff, enter_in;
   logic signed [rbch_pkg::T_W-1:0]     leave_ff, leave_in;
   logic [rbch_pkg::IDX_W-1:0]          cur_idx_ff, cur_idx_in;

   // divider
   logic [rbch_pkg::NUM_W-1:0]          num_ff, num_in;
   logic [rbch_pkg::DIR_W-1:0]          rem_ff, rem_in;
   logic [rbch_pkg::DMAG_W-1:0]         dmag_ff, dmag_in;
   logic [rbch_pkg::DCNT_W-1:0]         cnt_ff, cnt_in;
   logic                                neg_ff, neg_in;
   logic                                near_ff, near_in;

   // tracking
   logic signed [rbch_pkg::DIST_W-1:0]  dist_ff, dist_in;
   logic [rbch_pkg::IDX_W-1:0]          idx_ff, idx_in;
   logic                                any_ff, any_in;
   logic [rbch_pkg::CNT_W-1:0]          count_ff, count_in;

   // output register
   logic                                out_valid_ff, out_valid_in;
   logic                                out_found_ff, out_found_in;
   logic [rbch_pkg::IDX_W-1:0]          out_idx_ff, out_idx_in;
   logic signed [rbch_pkg::DIST_W-1:0]  out_dist_ff, out_dist_in;

   logic                                req_accept;
   logic                                csr_write;
   logic [2:0]                          csr_index;

   // per-axis selection
   logic signed [rbch_pkg::COORD_W-1:0] o_sel, ca_sel, cb_sel, lo_sel, hi_sel, c_sel;
   logic signed [rbch_pkg::DIR_W-1:0]   d_sel;
   logic signed [rbch_pkg::DIFF_W-1:0]  diff;
   logic signed [rbch_pkg::NUM_W-1:0]   numer;
   logic [rbch_pkg::NUM_W-1:0]          nmag;
   logic signed [rbch_pkg::DMAG_W-1:0]  dsx;
   logic [rbch_pkg::DMAG_W-1:0]         dmag;
   logic                                in_slab;

   // divider step and result
   logic [rbch_pkg::DMAG_W-1:0]         trial;
   logic [rbch_pkg::DMAG_W-1:0]         trial_diff;
   logic                                trial_ok;
   logic signed [rbch_pkg::T_W-1:0]     quot;
   logic signed [rbch_pkg::T_W-1:0]     floor0;
   logic signed [rbch_pkg::T_W-1:0]     t_sat;
   logic                                box_hit;

   assign req_accept    = req_box.valid && req_box.ready;
   assign req_box.ready = (state_ff == S_IDLE);

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   // register read-back
   always_comb begin
      case (csr_index)
         REG_ORIGIN_X: csr_prdata = origin_ff[0];
         REG_ORIGIN_Y: csr_prdata = origin_ff[1];
         REG_ORIGIN_Z: csr_prdata = origin_ff[2];
         REG_DIR_X:    csr_prdata = rbch_pkg::CSR_DATA_W'(unsigned'(dir_ff[0]));
         REG_DIR_Y:    csr_prdata = rbch_pkg::CSR_DATA_W'(unsigned'(dir_ff[1]));
         REG_DIR_Z:    csr_prdata = rbch_pkg::CSR_DATA_W'(unsigned'(dir_ff[2]));
         default:      csr_prdata = '0;
      endcase
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff[0] <= '0;
         origin_ff[1] <= '0;
         origin_ff[2] <= '0;
         dir_ff[0]    <= '0;
         dir_ff[1]    <= '0;
         dir_ff[2]    <= {1'b1, {(rbch_pkg::DIR_W-1){1'b0}}};
      end else if (csr_write) begin
         case (csr_index)
            REG_ORIGIN_X: origin_ff[0] <= csr_pwdata;
            REG_ORIGIN_Y: origin_ff[1] <= csr_pwdata;
            REG_ORIGIN_Z: origin_ff[2] <= csr_pwdata;
            REG_DIR_X:    dir_ff[0]    <= csr_pwdata[rbch_pkg::DIR_W-1:0];
            REG_DIR_Y:    dir_ff[1]    <= csr_pwdata[rbch_pkg::DIR_W-1:0];
            REG_DIR_Z:    dir_ff[2]    <= csr_pwdata[rbch_pkg::DIR_W-1:0];
            default: ;
         endcase
      end
   end

   // corners held for the box in work
   always_ff @(posedge clock) begin
      if (req_accept) begin
         corner_a_ff[0] <= req_box.corner_a_x;
         corner_a_ff[1] <= req_box.corner_a_y;
         corner_a_ff[2] <= req_box.corner_a_z;
         corner_b_ff[0] <= req_box.corner_b_x;
         corner_b_ff[1] <= req_box.corner_b_y;
         corner_b_ff[2] <= req_box.corner_b_z;
      end
   end

   // current axis: order corners, build numerator and divisor magnitudes
   always_comb begin
      o_sel   = origin_ff[axis_ff];
      d_sel   = dir_ff[axis_ff];
      ca_sel  = corner_a_ff[axis_ff];
      cb_sel  = corner_b_ff[axis_ff];
      lo_sel  = (ca_sel < cb_sel) ? ca_sel : cb_sel;
      hi_sel  = (ca_sel < cb_sel) ? cb_sel : ca_sel;
      c_sel   = side_ff ? hi_sel : lo_sel;
      diff    = rbch_pkg::DIFF_W'(c_sel) - rbch_pkg::DIFF_W'(o_sel);
      numer   = {diff, {rbch_pkg::FRAC_SHIFT{1'b0}}};
      nmag    = numer[rbch_pkg::NUM_W-1] ? unsigned'(-numer) : unsigned'(numer);
      dsx     = rbch_pkg::DMAG_W'(d_sel);
      dmag    = dsx[rbch_pkg::DMAG_W-1] ? unsigned'(-dsx) : unsigned'(dsx);
      in_slab = (lo_sel <= o_sel) && (o_sel <= hi_sel);
   end

   // one restoring step per cycle
   always_comb begin
      trial      = {rem_ff, num_ff[rbch_pkg::NUM_W-1]};
      trial_ok   = (trial >= dmag_ff);
      trial_diff = trial - dmag_ff;
   end

   // signed quotient, hit test and saturation
   always_comb begin
      quot    = neg_ff ? -signed'({1'b0, num_ff}) : signed'({1'b0, num_ff});
      floor0  = (enter_ff > 0) ? enter_ff : '0;
      box_hit = ok_ff && (leave_ff >= floor0);
      if (enter_ff > T_DIST_MAX) begin
         t_sat = T_DIST_MAX;
      end else if (enter_ff < T_DIST_MIN) begin
         t_sat = T_DIST_MIN;
      end else begin
         t_sat = enter_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      last_in      = last_ff;
      axis_in      = axis_ff;
      side_in      = side_ff;
      ok_in        = ok_ff;
      enter_in     = enter_ff;
      leave_in     = leave_ff;
      cur_idx_in   = cur_idx_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      dmag_in      = dmag_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      near_in      = near_ff;
      dist_in      = dist_ff;
      idx_in       = idx_ff;
      any_in       = any_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff && !rsp_hit.ready;
      out_found_in = out_found_ff;
      out_idx_in   = out_idx_ff;
      out_dist_in  = out_dist_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               last_in  = req_box.last_box;
               axis_in  = '0;
               side_in  = 1'b0;
               ok_in    = 1'b1;
               enter_in = T_NEG_INF;
               leave_in = T_POS_INF;
               if (count_ff < rbch_pkg::CNT_W'(rbch_pkg::MAX_BOXES)) begin
                  cur_idx_in = rbch_pkg::IDX_W'(count_ff);
                  count_in   = count_ff + 1'b1;
                  state_in   = S_SETUP;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SETUP: begin
            if (d_sel == '0) begin
               // zero direction: slab is all or nothing
               ok_in = ok_ff && in_slab;
               if (axis_ff == AXIS_LAST) begin
                  state_in = S_DECIDE;
               end else begin
                  axis_in = axis_ff + 1'b1;
               end
            end else begin
               num_in   = nmag;
               rem_in   = '0;
               dmag_in  = dmag;
               neg_in   = diff[rbch_pkg::DIFF_W-1] ^ d_sel[rbch_pkg::DIR_W-1];
               near_in  = !side_ff ^ d_sel[rbch_pkg::DIR_W-1];
               cnt_in   = rbch_pkg::DCNT_W'(rbch_pkg::NUM_W - 1);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in = trial_ok ? trial_diff[rbch_pkg::DIR_W-1:0]
                              : trial[rbch_pkg::DIR_W-1:0];
            num_in = {num_ff[rbch_pkg::NUM_W-2:0], trial_ok};
            if (cnt_ff == '0) begin
               state_in = S_APPLY;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_APPLY: begin
            if (near_ff) begin
               if (quot > enter_ff) enter_in = quot;
            end else begin
               if (quot < leave_ff) leave_in = quot;
            end
            if (!side_ff) begin
               side_in  = 1'b1;
               state_in = S_SETUP;
            end else begin
               side_in = 1'b0;
               if (axis_ff == AXIS_LAST) begin
                  state_in = S_DECIDE;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = S_SETUP;
               end
            end
         end
         S_DECIDE: begin
            // strictly smaller replaces; first hit always replaces
            if (box_hit && (!any_ff ||
                            signed'(t_sat[rbch_pkg::DIST_W-1:0]) < dist_ff)) begin
               dist_in = t_sat[rbch_pkg::DIST_W-1:0];
               idx_in  = cur_idx_ff;
               any_in  = 1'b1;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (!out_valid_ff || rsp_hit.ready) begin
               out_valid_in = 1'b1;
               out_found_in = any_ff;
               out_idx_in   = any_ff ? idx_ff : '0;
               out_dist_in  = any_ff ? dist_ff : '0;
               dist_in      = DIST_MAX;
               idx_in       = '0;
               any_in       = 1'b0;
               count_in     = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         any_ff       <= 1'b0;
         count_ff     <= '0;
         dist_ff      <= DIST_MAX;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         any_ff       <= any_in;
         count_ff     <= count_in;
         dist_ff      <= dist_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      last_ff      <= last_in;
      axis_ff      <= axis_in;
      side_ff      <= side_in;
      ok_ff        <= ok_in;
      enter_ff     <= enter_in;
      leave_ff     <= leave_in;
      cur_idx_ff   <= cur_idx_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      dmag_ff      <= dmag_in;
      cnt_ff       <= cnt_in;
      neg_ff       <= neg_in;
      near_ff      <= near_in;
      out_found_ff <= out_found_in;
      out_idx_ff   <= out_idx_in;
      out_dist_ff  <= out_dist_in;
   end

   assign rsp_hit.valid        = out_valid_ff;
   assign rsp_hit.hit_found    = out_found_ff;
   assign rsp_hit.hit_index    = out_idx_ff;
   assign rsp_hit.hit_distance = out_dist_ff;

endmodule

>>> rtl/core/rbch_checker.sv
// ----------------------------------------------------------------------------
// rbch_checker: port-level checks for the ray/box closest-hit block
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module rbch_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_found,
   input logic [rbch_pkg::IDX_W-1:0]         rsp_index,
   input logic signed [rbch_pkg::DIST_W-1:0] rsp_distance
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) &&
                                  $stable(rsp_index) && $stable(rsp_distance))
      else $error("stalled result changed");

   // a box in work keeps the request side closed
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a box is in work");

   // a miss reports zero index and distance
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_index == '0 && rsp_distance == '0)
      else $error("miss result carries data");

   // no result straight out of reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind ray_box_closest_hit rbch_checker u_rbch_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_box.valid),
   .req_ready    (req_box.ready),
   .rsp_valid    (rsp_hit.valid),
   .rsp_ready    (rsp_hit.ready),
   .rsp_found    (rsp_hit.hit_found),
   .rsp_index    (rsp_hit.hit_index),
   .rsp_distance (rsp_hit.hit_distance)
);

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for ray_box_closest_hit
// Streams boxes against a ray held in the csr_ registers. A local slab-test
// model predicts each list's closest hit, and every result request is
// compared field by field. Covers directed corner cases, random rays and
// boxes under several idle and stall mixes, the list limit and a long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int  LIMIT_CYCLES = 2_000_000;
   localparam int  DRAIN_CYCLES = 320;
   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

   typedef enum int {
      REG_ORIGIN_X = 0, REG_ORIGIN_Y, REG_ORIGIN_Z,
      REG_DIR_X, REG_DIR_Y, REG_DIR_Z
   } csr_reg_type;

   typedef struct {
      logic signed [rbch_pkg::COORD_W-1:0] a [3];
      logic signed [rbch_pkg::COORD_W-1:0] b [3];
      logic                                last;
   } box_type;

   typedef struct {
      logic                               found;
      logic [rbch_pkg::IDX_W-1:0]         index;
      logic signed [rbch_pkg::DIST_W-1:0] distance;
   } hit_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                            csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [rbch_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [rbch_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [rbch_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   rbch_req_if req_box ();
   rbch_rsp_if rsp_hit ();

   ray_box_closest_hit u_top (
      .clock, .reset, .req_box(req_box.sink), .rsp_hit(rsp_hit.source),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ray registers and tracking state of the local model
   logic signed [rbch_pkg::COORD_W-1:0] ray_org [3];
   logic signed [rbch_pkg::DIR_W-1:0]   ray_dir [3];
   longint                              track_dist;
   int                                  track_idx;
   bit                                  track_any;
   int                                  list_count;

   hit_type hits_pending [$];
   int   mismatches = 0;
   int   sender_idle_pct = 0;
   int   recv_stall_pct  = 0;
   int   holdoff_cycles  = 0;
   longint cycle_count = 0;

   initial begin
      req_box.valid = 1'b0;
      req_box.last_box = 1'b0;
      req_box.corner_a_x = '0; req_box.corner_a_y = '0; req_box.corner_a_z = '0;
      req_box.corner_b_x = '0; req_box.corner_b_y = '0; req_box.corner_b_z = '0;
      rsp_hit.ready = 1'b0;
   end

   function automatic void clear_tracking();
      track_dist = longint'(Q_MAX);
      track_idx  = 0;
      track_any  = 1'b0;
      list_count = 0;
   endfunction

   // one slab: narrows [enter, leave], clears ok when a zero-direction axis misses
   function automatic void slab_axis(longint o, longint d, longint a, longint b,
                                     inout longint enter, inout longint leave,
                                     inout bit ok);
      longint lo, hi, t0, t1, tmp;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      if (d == 0) begin
         if (!(lo <= o && o <= hi)) ok = 1'b0;
         return;
      end
      t0 = ((lo - o) * 32768) / d;
      t1 = ((hi - o) * 32768) / d;
      if (d < 0) begin
         tmp = t0; t0 = t1; t1 = tmp;
      end
      if (t0 > enter) enter = t0;
      if (t1 < leave) leave = t1;
   endfunction

   // closest-hit tracking for one accepted box request
   function automatic void predict_closest_hit(box_type bx);
      longint  enter, leave, floor0, t;
      bit      ok;
      hit_type h;
      if (list_count < rbch_pkg::MAX_BOXES) begin
         enter = 64'sh8000_0000_0000_0000;
         leave = 64'sh7FFF_FFFF_FFFF_FFFF;
         ok = 1'b1;
         for (int ax = 0; ax < 3; ax++)
            slab_axis(longint'(ray_org[ax]), longint'(ray_dir[ax]),
                      longint'(bx.a[ax]), longint'(bx.b[ax]), enter, leave, ok);
         floor0 = (enter > 0) ? enter : 0;
         if (ok && leave >= floor0) begin
            t = enter;
            if (t > longint'(Q_MAX)) t = longint'(Q_MAX);
            if (t < longint'(Q_MIN)) t = longint'(Q_MIN);
            if (!track_any || t < track_dist) begin
               track_dist = t;
               track_idx  = list_count;
               track_any  = 1'b1;
            end
         end
         list_count++;
      end
      if (!bx.last) return;
      h.found    = track_any;
      h.index    = track_any ? rbch_pkg::IDX_W'(track_idx) : '0;
      h.distance = track_any ? rbch_pkg::DIST_W'(track_dist) : '0;
      hits_pending.push_back(h);
      clear_tracking();
   endfunction

   // send one box request, with random idle cycles ahead of it
   task automatic send_box(box_type bx);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_box.valid <= 1'b0;
         @(posedge clock);
      end
      req_box.valid      <= 1'b1;
      req_box.corner_a_x <= bx.a[0]; req_box.corner_a_y <= bx.a[1];
      req_box.corner_a_z <= bx.a[2];
      req_box.corner_b_x <= bx.b[0]; req_box.corner_b_y <= bx.b[1];
      req_box.corner_b_z <= bx.b[2];
      req_box.last_box   <= bx.last;
      @(posedge clock);
      while (!req_box.ready) @(posedge clock);
      predict_closest_hit(bx);
   endtask

   // setup, access, then idle before the next write
   task automatic csr_write(csr_reg_type r, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= rbch_pkg::CSR_ADDR_W'(4 * int'(r));
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      case (r)
         REG_ORIGIN_X: ray_org[0] = value;
         REG_ORIGIN_Y: ray_org[1] = value;
         REG_ORIGIN_Z: ray_org[2] = value;
         REG_DIR_X:    ray_dir[0] = value[15:0];
         REG_DIR_Y:    ray_dir[1] = value[15:0];
         REG_DIR_Z:    ray_dir[2] = value[15:0];
         default: ;
      endcase
   endtask

   // wait until every result is in and the last box has left the block
   task automatic wait_idle();
      req_box.valid <= 1'b0;
      @(posedge clock);
      while (hits_pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                          logic [15:0] dx, logic [15:0] dy, logic [15:0] dz);
      wait_idle();
      csr_write(REG_ORIGIN_X, ox);
      csr_write(REG_ORIGIN_Y, oy);
      csr_write(REG_ORIGIN_Z, oz);
      csr_write(REG_DIR_X, {16'h0, dx});
      csr_write(REG_DIR_Y, {16'h0, dy});
      csr_write(REG_DIR_Z, {16'h0, dz});
   endtask

   function automatic box_type make_box(logic signed [31:0] ax, logic signed [31:0] ay,
                                        logic signed [31:0] az, logic signed [31:0] bx,
                                        logic signed [31:0] by, logic signed [31:0] bz,
                                        logic last);
      box_type b;
      b.a[0] = ax; b.a[1] = ay; b.a[2] = az;
      b.b[0] = bx; b.b[1] = by; b.b[2] = bz;
      b.last = last;
      return b;
   endfunction

   function automatic logic [15:0] rand_dir();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'h8000;
         2: return 16'h7FFF;
         3: return 16'($urandom_range(1, 3));
         default: return 16'($urandom);
      endcase
   endfunction

   // coordinate near a reference point, sometimes anywhere
   function automatic logic signed [31:0] rand_coord(logic signed [31:0] centre);
      if ($urandom_range(9) == 0) return 32'($urandom);
      return centre + 32'($signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
   endfunction

   function automatic box_type rand_box(logic last);
      box_type b;
      logic signed [31:0] c, half;
      int kind;
      kind = $urandom_range(9);
      for (int ax = 0; ax < 3; ax++) begin
         if (kind == 0) begin
            // noise: anywhere at all
            b.a[ax] = 32'($urandom);
            b.b[ax] = 32'($urandom);
         end else begin
            // box placed along the ray, mostly straddling it
            c = ray_org[ax] + 32'($signed(longint'(ray_dir[ax]) *
                                          longint'($urandom_range(0, 200))));
            half = 32'($urandom_range(0, 32'h0020_0000));
            if (kind == 1) half = 0;
            b.a[ax] = rand_coord(c) - half;
            b.b[ax] = b.a[ax] + 2 * half + 32'($urandom_range(0, 255));
            if ($urandom_range(1)) begin
               c = b.a[ax]; b.a[ax] = b.b[ax]; b.b[ax] = c;
            end
         end
      end
      b.last = last;
      return b;
   endfunction

   task automatic random_ray();
      logic [31:0] o [3];
      for (int ax = 0; ax < 3; ax++)
         o[ax] = ($urandom_range(4) == 0) ? 32'($urandom)
                                          : 32'($signed($urandom_range(0, 32'h0100_0000))
                                                - 32'sh0080_0000);
      set_ray(o[0], o[1], o[2], rand_dir(), rand_dir(), rand_dir());
   endtask

   task automatic send_random_lists(int n_boxes);
      int left, len;
      left = n_boxes;
      while (left > 0) begin
         len = $urandom_range(1, 10);
         if (len > left) len = left;
         for (int i = 0; i < len; i++) send_box(rand_box(i == len - 1));
         left -= len;
      end
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_reset_ray();
      // default ray: origin 0 looking down -z
      send_box(make_box(-Q_ONE, -Q_ONE, -10 * Q_ONE, Q_ONE, Q_ONE, -5 * Q_ONE, 1'b0));
      send_box(make_box(-Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE, -Q_ONE, 1'b0));
      send_box(make_box(Q_ONE, Q_ONE, -3 * Q_ONE, -Q_ONE, -Q_ONE, -2 * Q_ONE, 1'b1));
      // miss on a zero-direction axis
      send_box(make_box(Q_ONE, -Q_ONE, -9 * Q_ONE, 2 * Q_ONE, Q_ONE, -Q_ONE, 1'b1));
      // equal distances on the first two boxes, then a box around the origin beats both
      send_box(make_box(0, 0, -Q_ONE, 0, 0, -4 * Q_ONE, 1'b0));
      send_box(make_box(0, 0, -Q_ONE, 0, 0, -4 * Q_ONE, 1'b0));
      send_box(make_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b1));
      // box behind the ray
      send_box(make_box(-Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE, 2 * Q_ONE, 1'b1));
   endtask

   task automatic test_special_rays();
      // all-zero direction: inside gives the most negative distance
      set_ray(32'(Q_ONE), 0, 0, 16'h0, 16'h0, 16'h0);
      send_box(make_box(0, -Q_ONE, -Q_ONE, 2 * Q_ONE, Q_ONE, Q_ONE, 1'b0));
      send_box(make_box(2 * Q_ONE, -Q_ONE, -Q_ONE, 3 * Q_ONE, Q_ONE, Q_ONE, 1'b1));
      // saturation from an extreme origin, and a first hit at the top value
      set_ray(32'(Q_MIN), 0, 0, 16'h7FFF, 16'h0, 16'h0);
      send_box(make_box(Q_MAX - 1, -1, -1, Q_MAX, 1, 1, 1'b0));
      send_box(make_box(0, 0, 0, Q_MAX, 0, 0, 1'b1));
      set_ray(32'(Q_MAX), 32'(Q_MAX), 32'(Q_MIN), 16'h8000, 16'h0001, 16'h8000);
      send_box(make_box(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b0));
      send_box(make_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b1));
      // non-unit tiny direction
      set_ray(0, 0, 0, 16'h0001, 16'hFFFF, 16'h0002);
      send_box(make_box(Q_ONE, -Q_ONE, Q_ONE, 2 * Q_ONE, -2 * Q_ONE, 3 * Q_ONE, 1'b0));
      send_box(make_box(-Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b1));
   endtask

   task automatic test_random_phase(int idle_pct, int stall_pct, int n_boxes);
      sender_idle_pct = idle_pct;
      recv_stall_pct  = stall_pct;
      for (int r = 0; r < 3; r++) begin
         random_ray();
         send_random_lists(n_boxes / 3);
      end
   endtask

   task automatic test_list_limit();
      sender_idle_pct = 0;
      recv_stall_pct  = 0;
      set_ray(0, 0, 0, 16'h0, 16'h0, 16'h0);
      for (int i = 0; i < rbch_pkg::MAX_BOXES + 4; i++) begin
         if (i == rbch_pkg::MAX_BOXES - 1 || i >= rbch_pkg::MAX_BOXES)
            send_box(make_box(-1, -1, -1, 1, 1, 1, i == rbch_pkg::MAX_BOXES + 3));
         else if ($urandom_range(3) == 0)
            send_box(make_box(-1, -1, -1, 1, 1, 1, 1'b0));
         else
            send_box(make_box(1, -1, -1, 2, 1, 1, 1'b0));
      end
   endtask

   task automatic test_back_pressure();
      sender_idle_pct = 0;
      recv_stall_pct  = 0;
      random_ray();
      holdoff_cycles = 3000;
      for (int i = 0; i < 8; i++) send_box(rand_box(1'b1));
      send_random_lists(20);
   endtask

   // receiver: random stalls and the long hold-off
   always @(posedge clock) begin
      if (holdoff_cycles > 0) begin
         holdoff_cycles <= holdoff_cycles - 1;
         rsp_hit.ready  <= 1'b0;
      end else begin
         rsp_hit.ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      hit_type h;
      if (!reset && rsp_hit.valid && rsp_hit.ready) begin
         if (hits_pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result request: found %0b index %0d distance %0d",
                        rsp_hit.hit_found, rsp_hit.hit_index, rsp_hit.hit_distance);
         end else begin
            h = hits_pending.pop_front();
            if (rsp_hit.hit_found !== h.found || rsp_hit.hit_index !== h.index ||
                rsp_hit.hit_distance !== h.distance) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: found %0b/%0b index %0d/%0d distance %0d/%0d",
                           h.found, rsp_hit.hit_found, h.index, rsp_hit.hit_index,
                           h.distance, rsp_hit.hit_distance);
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      ray_org[0] = 0; ray_org[1] = 0; ray_org[2] = 0;
      ray_dir[0] = 0; ray_dir[1] = 0; ray_dir[2] = 16'sh8000;
      clear_tracking();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_ray();
      test_special_rays();
      test_random_phase(0, 0, 90);
      test_random_phase(56, 0, 90);
      test_random_phase(0, 56, 90);
      test_random_phase(30, 30, 90);
      test_random_phase(0, 0, 90);
      test_list_limit();
      test_back_pressure();

      wait_idle();
      if (mismatches == 0 && hits_pending.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/rbch_pkg.sv
rtl/core/rbch_req_if.sv
rtl/core/ray_box_closest_hit.sv
rtl/core/rbch_checker.sv
dv/tb_top.sv
